// File: hdl/wrcp_pkg.sv
package wrcp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TDATA_W  = 112;
	localparam int unsigned TUSER_W  = 2;
	localparam int unsigned S_TDATA_W = 8;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;
	localparam logic [15:0] FMT_PCM  = 16'h0001;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_RIFF   = 3'd1,
		ERR_WAVE   = 3'd2,
		ERR_FMT    = 3'd3,
		ERR_NODATA = 3'd4,
		ERR_TRUNC  = 3'd5
	} err_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eos;
	} in_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload_byte;
		logic              payload_last;
		err_t              error_code;
		logic [15:0]       channel_count;
		logic [31:0]       sample_rate;
		logic [15:0]       bits_per_sample;
		logic [31:0]       data_size;
	} result_t;

endpackage

// File: hdl/wrcp_in_stage.sv
module wrcp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wrcp_pkg::in_item_t  in_item,
	input  logic                take,
	output logic                valid_s1,
	output wrcp_pkg::in_item_t  item_s1
);

	logic valid_q;

	// the stage is emptied by the core in the same cycle it is refilled
	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: hdl/wrcp_core.sv
module wrcp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wrcp_pkg::in_item_t  item,
	output logic                res_valid,
	output wrcp_pkg::result_t   res
);

	typedef enum logic [2:0] {
		PH_RIFF, PH_FSIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP, PH_DATA, PH_DRAIN
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  bc_q, bc_n;
	logic [31:0] fs_q, fs_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] rem_q, rem_n;
	logic [15:0] ch_q, ch_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bps_q, bps_n;
	logic [31:0] dsize_q, dsize_n;

	logic                ev;
	wrcp_pkg::kind_t     ev_kind;
	logic [7:0]          ev_byte;
	logic                ev_last;
	wrcp_pkg::err_t      ev_err;
	logic                halt;
	logic                clr;
	logic [3:0]          bc_inc;
	logic [31:0]         rem_dec;
	logic [7:0]          b;
	logic                eos;

	assign b       = item.data;
	assign eos     = item.eos;
	assign bc_inc  = bc_q + 4'd1;
	assign rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;

	always_comb begin
		phase_n = phase_q;
		bc_n    = bc_q;
		fs_n    = fs_q;
		tag_n   = tag_q;
		rem_n   = rem_q;
		ch_n    = ch_q;
		rate_n  = rate_q;
		bps_n   = bps_q;
		dsize_n = dsize_q;
		ev      = 1'b0;
		ev_kind = wrcp_pkg::KIND_ERROR;
		ev_byte = 8'd0;
		ev_last = 1'b0;
		ev_err  = wrcp_pkg::ERR_NONE;
		halt    = 1'b0;
		clr     = 1'b0;

		unique case (phase_q)
			PH_RIFF: begin
				tag_n = {tag_q[23:0], b};
				bc_n  = bc_inc;
				if (bc_inc == 4'd4) begin
					if (tag_n != wrcp_pkg::TAG_RIFF) begin
						ev = 1'b1; ev_err = wrcp_pkg::ERR_RIFF;
					end else begin
						phase_n = PH_FSIZE;
						bc_n    = 4'd0;
						tag_n   = 32'd0;
						if (eos) begin
							ev = 1'b1; ev_err = wrcp_pkg::ERR_WAVE;
						end
					end
				end else if (eos) begin
					ev = 1'b1; ev_err = wrcp_pkg::ERR_RIFF;
				end
			end
			PH_FSIZE: begin
				bc_n = bc_inc;
				if (bc_inc == 4'd4) begin
					phase_n = PH_WAVE;
					bc_n    = 4'd0;
				end
				if (eos) begin
					ev = 1'b1; ev_err = wrcp_pkg::ERR_WAVE;
				end
			end
			PH_WAVE: begin
				tag_n = {tag_q[23:0], b};
				bc_n  = bc_inc;
				if (bc_inc == 4'd4) begin
					if (tag_n != wrcp_pkg::TAG_WAVE) begin
						ev = 1'b1; ev_err = wrcp_pkg::ERR_WAVE;
					end else begin
						phase_n = PH_HDR;
						bc_n    = 4'd0;
						fs_n    = 32'd0;
						tag_n   = 32'd0;
						if (eos) begin
							ev = 1'b1; ev_err = wrcp_pkg::ERR_NODATA;
						end
					end
				end else if (eos) begin
					ev = 1'b1; ev_err = wrcp_pkg::ERR_WAVE;
				end
			end
			PH_HDR: begin
				// tag is big-endian, size little-endian
				if (!bc_q[2]) tag_n = {tag_q[23:0], b};
				else fs_n[8*bc_q[1:0] +: 8] = b;
				bc_n = {1'b0, bc_q[2:0]} + 4'd1;
				if (bc_q[2:0] != 3'd7) begin
					if (eos) begin
						ev = 1'b1; ev_err = wrcp_pkg::ERR_NODATA;
					end
				end else begin
					rem_n = fs_n;
					bc_n  = 4'd0;
					if (tag_n == wrcp_pkg::TAG_FMT) begin
						phase_n = PH_FMT;
						fs_n    = 32'd0;
						if (eos) begin
							ev = 1'b1; ev_err = wrcp_pkg::ERR_NODATA;
						end
					end else if (tag_n == wrcp_pkg::TAG_DATA) begin
						dsize_n = fs_n;
						if (fs_n == 32'd0) begin
							ev = 1'b1; ev_kind = wrcp_pkg::KIND_DONE;
						end else begin
							phase_n = PH_DATA;
							if (eos) begin
								ev = 1'b1; ev_err = wrcp_pkg::ERR_TRUNC;
							end
						end
					end else begin
						if (fs_n == 32'd0) begin
							phase_n = PH_HDR;
							fs_n    = 32'd0;
							tag_n   = 32'd0;
						end else begin
							phase_n = PH_SKIP;
						end
						if (eos) begin
							ev = 1'b1; ev_err = wrcp_pkg::ERR_NODATA;
						end
					end
				end
			end
			PH_FMT: begin
				bc_n = bc_inc;
				case (bc_q)
					4'd0: fs_n[7:0] = b;
					4'd1: fs_n[15:8] = b;
					4'd2, 4'd3: ch_n[8*bc_q[0] +: 8] = b;
					4'd4, 4'd5, 4'd6, 4'd7: rate_n[8*bc_q[1:0] +: 8] = b;
					4'd14, 4'd15: bps_n[8*bc_q[0] +: 8] = b;
					default: ;
				endcase
				if (bc_q == 4'd1 && fs_n[15:0] != wrcp_pkg::FMT_PCM) begin
					ev = 1'b1; ev_err = wrcp_pkg::ERR_FMT;
				end else begin
					if (bc_q == 4'd15) begin
						rem_n = (rem_q >= wrcp_pkg::FMT_BODY_LEN)
							? rem_q - wrcp_pkg::FMT_BODY_LEN : 32'd0;
						bc_n  = 4'd0;
						if (rem_n == 32'd0) begin
							phase_n = PH_HDR;
							fs_n    = 32'd0;
							tag_n   = 32'd0;
						end else begin
							phase_n = PH_SKIP;
						end
					end
					if (eos) begin
						ev = 1'b1; ev_err = wrcp_pkg::ERR_NODATA;
					end
				end
			end
			PH_SKIP: begin
				rem_n = rem_dec;
				if (rem_dec == 32'd0) begin
					phase_n = PH_HDR;
					bc_n    = 4'd0;
					fs_n    = 32'd0;
					tag_n   = 32'd0;
				end
				if (eos) begin
					ev = 1'b1; ev_err = wrcp_pkg::ERR_NODATA;
				end
			end
			PH_DATA: begin
				rem_n = rem_dec;
				ev    = 1'b1;
				if (rem_dec == 32'd0) begin
					ev_kind = wrcp_pkg::KIND_PAYLOAD;
					ev_byte = b;
					ev_last = 1'b1;
				end else if (eos) begin
					ev_err = wrcp_pkg::ERR_TRUNC;
				end else begin
					ev_kind = wrcp_pkg::KIND_PAYLOAD;
					ev_byte = b;
				end
				halt = (rem_dec == 32'd0) || eos;
			end
			PH_DRAIN: begin
				clr = eos;
			end
			default: ;
		endcase

		// an error or finish request stops the parse as well; the byte flagged end of stream rearms it
		if (ev && ev_kind != wrcp_pkg::KIND_PAYLOAD) halt = 1'b1;
		if (halt) begin
			if (eos) clr = 1'b1;
			else phase_n = PH_DRAIN;
		end
	end

	assign res_valid           = step && ev;
	assign res.kind            = ev_kind;
	assign res.payload_byte    = ev_byte;
	assign res.payload_last    = ev_last;
	assign res.error_code      = ev_err;
	assign res.channel_count   = ch_n;
	assign res.sample_rate     = rate_n;
	assign res.bits_per_sample = bps_n;
	assign res.data_size       = dsize_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			bc_q    <= 4'd0;
			fs_q    <= 32'd0;
			tag_q   <= 32'd0;
			rem_q   <= 32'd0;
			ch_q    <= 16'd0;
			rate_q  <= 32'd0;
			bps_q   <= 16'd0;
			dsize_q <= 32'd0;
		end else if (step) begin
			if (clr) begin
				phase_q <= PH_RIFF;
				bc_q    <= 4'd0;
				fs_q    <= 32'd0;
				tag_q   <= 32'd0;
				rem_q   <= 32'd0;
				ch_q    <= 16'd0;
				rate_q  <= 32'd0;
				bps_q   <= 16'd0;
				dsize_q <= 32'd0;
			end else begin
				phase_q <= phase_n;
				bc_q    <= bc_n;
				fs_q    <= fs_n;
				tag_q   <= tag_n;
				rem_q   <= rem_n;
				ch_q    <= ch_n;
				rate_q  <= rate_n;
				bps_q   <= bps_n;
				dsize_q <= dsize_n;
			end
		end
	end

endmodule

// File: hdl/wrcp_out_stage.sv
module wrcp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  wrcp_pkg::result_t  res,
	output logic               free,
	output logic               valid_s2,
	output wrcp_pkg::result_t  res_s2,
	input  logic               out_ready
);

	logic valid_q;

	assign free     = !valid_q || out_ready;
	assign valid_s2 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

// File: hdl/wav_riff_chunk_parser_top.sv
// Channel  Dir  Signals                      Carries
// s_*      in   tvalid tready tdata tlast    one file byte, end of stream
// m_*      out  tvalid tready tdata tlast    payload/finish/error request,
//                             tuser          captured format fields
//
// One byte per cycle sustained while m_tready holds high; an accepted byte is
// loaded into the input register, then its request is loaded into the result
// register through the parse logic and shows on m_*.
// Every field is parsed in a single pass per byte; no stage iterates.
// arst_n clears the parse state, captured format fields and both valid flags.
// A stalled m_* side holds the result register; the input register keeps
// taking bytes until it is also full, then s_tready drops.
module wav_riff_chunk_parser_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wrcp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
	input  logic                            s_tlast,   // end_of_stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] payload_byte, [10:8] error_code, [26:11] channel_count,
	// [58:27] sample_rate, [74:59] bits_per_sample, [106:75] data_size, rest 0
	output logic [wrcp_pkg::TDATA_W-1:0]    m_tdata,
	output logic                            m_tlast,   // payload_last
	output logic [wrcp_pkg::TUSER_W-1:0]    m_tuser    // [1:0] out_kind
);

	wrcp_pkg::in_item_t in_item;
	wrcp_pkg::in_item_t item_s1;
	wrcp_pkg::result_t  res;
	wrcp_pkg::result_t  res_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               free;
	logic               step;
	logic               res_valid;

	assign in_item.data = s_tdata;
	assign in_item.eos  = s_tlast;
	assign step         = valid_s1 && free;

	wrcp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.take     (free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wrcp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wrcp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (free),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2),
		.out_ready (m_tready)
	);

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.payload_last;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {5'd0, res_s2.data_size, res_s2.bits_per_sample,
		res_s2.sample_rate, res_s2.channel_count, res_s2.error_code,
		res_s2.payload_byte};

endmodule

// File: hdl/wrcp_checker.sv
module wrcp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [wrcp_pkg::TDATA_W-1:0]  m_tdata,
	input logic                          m_tlast,
	input logic [wrcp_pkg::TUSER_W-1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_last_payload_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != wrcp_pkg::KIND_PAYLOAD |-> !m_tlast && m_tdata[7:0] == 8'd0)
		else $error("finish or error request carries payload");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == wrcp_pkg::KIND_ERROR |->
			m_tdata[10:8] != wrcp_pkg::ERR_NONE && m_tdata[10:8] <= wrcp_pkg::ERR_TRUNC)
		else $error("error request with bad code");

	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != wrcp_pkg::KIND_ERROR |->
			m_tdata[10:8] == wrcp_pkg::ERR_NONE && m_tuser != 2'd3)
		else $error("error code outside an error request");

	a_no_result_without_input: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 2))
		else $error("request without a byte in flight");

endmodule

bind wav_riff_chunk_parser_top wrcp_checker u_wrcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
